// File: rtl/bir_pkg.sv
// ---------------------------------------------------------------------------
// Bicubic resize package
// Shared widths, types and the size and tap helpers of the bicubic image scaler.
// ---------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

  localparam int MaxDim    = 256;
  localparam int DimBits   = 8;
  localparam int SizeBits  = 9;
  localparam int FracBits  = 16;
  localparam int RatioBits = DimBits + FracBits;
  localparam int PosBits   = RatioBits + SizeBits;
  localparam int SampBits  = 34;
  localparam int MuBits    = FracBits + 1;
  localparam int AddrBits  = 2 * DimBits;

  typedef logic signed [SampBits-1:0] samp_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegInWidth   = 2'd0;
  localparam logic [1:0] RegInHeight  = 2'd1;
  localparam logic [1:0] RegOutWidth  = 2'd2;
  localparam logic [1:0] RegOutHeight = 2'd3;

  // Command codes.
  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdCompute = 1'b1;

  typedef struct packed {
    logic [DimBits-1:0] t0;
    logic [DimBits-1:0] t1;
    logic [DimBits-1:0] t2;
    logic [DimBits-1:0] t3;
  } taps_t;

  // Size register write: zero reads as one, large values saturate.
  function automatic logic [SizeBits-1:0] size_sat(input logic [SizeBits-1:0] v);
    logic [SizeBits-1:0] r;
    if (v == '0) r = SizeBits'(1);
    else if (v > SizeBits'(MaxDim)) r = SizeBits'(MaxDim);
    else r = v;
    return r;
  endfunction

  // Clamp an integer source index to size-1.
  function automatic logic [DimBits-1:0] clamp_idx(input logic [PosBits-FracBits:0] v,
                                                    input logic [SizeBits-1:0] size);
    logic [PosBits-FracBits:0] lim;
    lim = (PosBits-FracBits+1)'(size - SizeBits'(1));
    return (v > lim) ? lim[DimBits-1:0] : v[DimBits-1:0];
  endfunction

  // Four taps of one axis from the position, the ratio and the coordinate.
  function automatic taps_t make_taps(input logic [PosBits-1:0] pos,
                                      input logic [RatioBits-1:0] ratio,
                                      input logic k_nz,
                                      input logic [SizeBits-1:0] size);
    logic [PosBits-1:0] prv;
    logic [PosBits-1:0] nxt;
    logic [PosBits-FracBits:0] ll, fl, ce, hh;
    taps_t t;
    prv = pos - PosBits'(ratio);
    nxt = pos + PosBits'(ratio);
    ll = k_nz ? (PosBits-FracBits+1)'(prv[PosBits-1:FracBits]) : '0;
    fl = (PosBits-FracBits+1)'(pos[PosBits-1:FracBits]);
    ce = fl + (PosBits-FracBits+1)'(pos[FracBits-1:0] != '0);
    hh = (PosBits-FracBits+1)'(nxt[PosBits-1:FracBits])
       + (PosBits-FracBits+1)'(nxt[FracBits-1:0] != '0);
    t.t0 = clamp_idx(ll, size);
    t.t1 = clamp_idx(fl, size);
    t.t2 = clamp_idx(ce, size);
    t.t3 = clamp_idx(hh, size);
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bir_frame_ram.sv
// ---------------------------------------------------------------------------
// Frame store
// Single-port source image memory with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module bir_frame_ram (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [bir_pkg::AddrBits-1:0] addr_i,
  input  wire logic [7:0]                   wdata_i,
  output logic      [7:0]                   rdata_o
);

  logic [7:0] mem [2**bir_pkg::AddrBits];

  // One access per cycle: write or registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bir_ratio_div.sv
// ---------------------------------------------------------------------------
// Ratio divider
// Restoring divider, one quotient bit per cycle, for the scale ratio.
// ---------------------------------------------------------------------------
`default_nettype none

module bir_ratio_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bir_pkg::SizeBits-1:0]  in_size_i,
  input  wire logic [bir_pkg::SizeBits-1:0]  out_size_i,
  output logic                               done_o,
  output logic [bir_pkg::RatioBits-1:0]      ratio_o
);

  localparam int CntBits = $clog2(bir_pkg::RatioBits + 1);

  logic [CntBits-1:0]              cnt_q, cnt_d;
  logic [bir_pkg::RatioBits-1:0]   quo_q, quo_d;
  logic [bir_pkg::DimBits:0]       rem_q, rem_d;
  logic [bir_pkg::DimBits-1:0]     dvs_q, dvs_d;
  logic                            zero_q, zero_d;
  logic                            run_q, run_d;
  logic                            done_q, done_d;
  logic [bir_pkg::DimBits:0]       trial;

  assign trial   = {rem_q[bir_pkg::DimBits-1:0], quo_q[bir_pkg::RatioBits-1]};
  assign done_o  = done_q;
  assign ratio_o = zero_q ? '0 : quo_q;

  // Shift in one dividend bit and subtract when it fits.
  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    zero_d = zero_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = {in_size_i[bir_pkg::DimBits-1:0] - bir_pkg::DimBits'(1),
                bir_pkg::FracBits'(0)};
      if (in_size_i == bir_pkg::SizeBits'(1)) quo_d = '0;
      dvs_d  = bir_pkg::DimBits'(out_size_i - bir_pkg::SizeBits'(1));
      zero_d = (out_size_i <= bir_pkg::SizeBits'(1));
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[bir_pkg::RatioBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[bir_pkg::RatioBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(bir_pkg::RatioBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    zero_q <= zero_d;
  end

endmodule

`default_nettype wire

// File: rtl/bir_cubic.sv
// ---------------------------------------------------------------------------
// Cubic unit
// Catmull-Rom cubic by Horner's rule on one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module bir_cubic (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire bir_pkg::samp_t              p_i [4],
  input  wire logic [bir_pkg::FracBits-1:0] mu_i,
  output logic                             done_o,
  output bir_pkg::samp_t                   res_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_HALF} state_e;

  localparam int ProdBits = bir_pkg::SampBits + bir_pkg::MuBits;

  state_e                           state_q;
  logic [1:0]                       step_q;
  logic                             done_q;
  bir_pkg::samp_t                   acc_q, a1_q, a2_q, a3_q, res_q, a_sel;
  logic signed [bir_pkg::MuBits-1:0] mu_q;
  logic signed [ProdBits-1:0]       prod_q;
  logic signed [ProdBits-1:0]       rnd;

  assign done_o = done_q;
  assign res_o  = res_q;
  assign rnd    = (prod_q + ProdBits'(1 << (bir_pkg::FracBits - 1))) >>> bir_pkg::FracBits;

  always_comb begin
    case (step_q)
      2'd0:    a_sel = a1_q;
      2'd1:    a_sel = a2_q;
      default: a_sel = a3_q;
    endcase
  end

  // Sequencer: three multiply and add rounds, then the halving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ADD;
        S_ADD: begin
          step_q  <= step_q + 2'd1;
          state_q <= (step_q == 2'd2) ? S_HALF : S_MUL;
        end
        S_HALF: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acc_q <= 3 * p_i[1] - 3 * p_i[2] + p_i[3] - p_i[0];
          a1_q  <= 2 * p_i[0] - 5 * p_i[1] + 4 * p_i[2] - p_i[3];
          a2_q  <= p_i[2] - p_i[0];
          a3_q  <= 2 * p_i[1];
          mu_q  <= {1'b0, mu_i};
        end
      end
      S_MUL:  prod_q <= acc_q * mu_q;
      S_ADD:  acc_q  <= bir_pkg::SampBits'(rnd) + a_sel;
      S_HALF: res_q  <= (acc_q + bir_pkg::SampBits'(1)) >>> 1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bicubic_image_resize_core.sv
// ---------------------------------------------------------------------------
// Bicubic image resize core
// Frame store plus a sequenced bicubic interpolator for one output pixel.
// ---------------------------------------------------------------------------
// A write request (cmd 0) is stored in the frame store and busy stays low. A
// compute request (cmd 1) holds busy high through the serial ratio dividers,
// position and taps, then for each of four source rows the reads on the
// single frame store port and the shared cubic multiplier, then the column
// cubic and the rounding.
// The result is shown on the result ports for exactly one cycle with done_o
// high, in the first cycle with busy low; a new request can be accepted in
// that same cycle. The receiver cannot stall the result and must take it in
// that cycle.
`default_nettype none

module bicubic_image_resize_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       cmd_i,
  input  wire logic [7:0] col_i,
  input  wire logic [7:0] row_i,
  input  wire logic [7:0] pixel_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  output logic            done_o,
  output logic [7:0]      out_col_o,
  output logic [7:0]      out_row_o,
  output logic [7:0]      value_o,
  output logic            clipped_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_POS, S_TAPS, S_RD, S_CAP, S_CUB, S_ROW, S_FIN
  } state_e;

  localparam int SB = bir_pkg::SizeBits;

  state_e                          state_q;
  logic [SB-1:0]                   in_w_q, in_h_q, out_w_q, out_h_q;
  logic [7:0]                      col_q, row_q;
  logic [1:0]                      tx_q, ty_q;
  logic                            cub_last_q, done_q, clip_q;
  logic [7:0]                      value_q;
  logic [bir_pkg::PosBits-1:0]     posx_q, posy_q;
  bir_pkg::taps_t                  tapx_q, tapy_q;
  bir_pkg::samp_t                  pix_q [4];
  bir_pkg::samp_t                  rows_q [4];
  bir_pkg::samp_t                  cub_p [4];
  bir_pkg::samp_t                  cub_res;
  bir_pkg::samp_t                  fin;
  logic [bir_pkg::FracBits-1:0]    cub_mu;
  logic                            cub_start, cub_done, div_start, divx_done, divy_done;
  logic [bir_pkg::RatioBits-1:0]   ratiox, ratioy;
  logic [7:0]                      cur_x, cur_y, rdata;
  logic                            ram_we;
  logic [bir_pkg::AddrBits-1:0]    ram_addr;
  logic                            accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign value_o     = value_q;
  assign clipped_o   = clip_q;
  assign out_col_o   = col_q;
  assign out_row_o   = row_q;

  // Tap selection for the current frame store read.
  always_comb begin
    case (tx_q)
      2'd0:    cur_x = tapx_q.t0;
      2'd1:    cur_x = tapx_q.t1;
      2'd2:    cur_x = tapx_q.t2;
      default: cur_x = tapx_q.t3;
    endcase
    case (ty_q)
      2'd0:    cur_y = tapy_q.t0;
      2'd1:    cur_y = tapy_q.t1;
      2'd2:    cur_y = tapy_q.t2;
      default: cur_y = tapy_q.t3;
    endcase
  end

  assign ram_we   = accept && (cmd_i == bir_pkg::CmdWrite);
  assign ram_addr = ram_we ? {row_i, col_i} : {cur_y, cur_x};
  assign div_start = accept && (cmd_i == bir_pkg::CmdCompute);

  bir_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pixel_i),
    .rdata_o (rdata)
  );

  bir_ratio_div u_divx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .in_size_i  (in_w_q),
    .out_size_i (out_w_q),
    .done_o     (divx_done),
    .ratio_o    (ratiox)
  );

  bir_ratio_div u_divy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .in_size_i  (in_h_q),
    .out_size_i (out_h_q),
    .done_o     (divy_done),
    .ratio_o    (ratioy)
  );

  // The row pass uses the gathered pixels, the column pass the row results.
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      cub_p[n] = cub_last_q ? rows_q[n] : pix_q[n];
    end
  end
  assign cub_mu = cub_last_q ? posy_q[bir_pkg::FracBits-1:0] : posx_q[bir_pkg::FracBits-1:0];
  assign cub_start = (state_q == S_CUB);

  bir_cubic u_cubic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cub_start),
    .p_i     (cub_p),
    .mu_i    (cub_mu),
    .done_o  (cub_done),
    .res_o   (cub_res)
  );

  assign fin = (cub_res + bir_pkg::SampBits'(1 << (bir_pkg::FracBits - 1)))
               >>> bir_pkg::FracBits;

  // Size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w_q  <= SB'(bir_pkg::MaxDim);
      in_h_q  <= SB'(bir_pkg::MaxDim);
      out_w_q <= SB'(bir_pkg::MaxDim);
      out_h_q <= SB'(bir_pkg::MaxDim);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bir_pkg::RegInWidth:   in_w_q  <= bir_pkg::size_sat(cfg_data_i);
        bir_pkg::RegInHeight:  in_h_q  <= bir_pkg::size_sat(cfg_data_i);
        bir_pkg::RegOutWidth:  out_w_q <= bir_pkg::size_sat(cfg_data_i);
        bir_pkg::RegOutHeight: out_h_q <= bir_pkg::size_sat(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Main sequencer: ratio, taps, sixteen reads with four row cubics, column cubic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tx_q       <= '0;
      ty_q       <= '0;
      cub_last_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (div_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV:  if (divx_done && divy_done) state_q <= S_POS;
        S_POS:  state_q <= S_TAPS;
        S_TAPS: begin
          tx_q       <= '0;
          ty_q       <= '0;
          cub_last_q <= 1'b0;
          state_q    <= S_RD;
        end
        S_RD:   state_q <= S_CAP;
        S_CAP: begin
          tx_q    <= tx_q + 2'd1;
          state_q <= (tx_q == 2'd3) ? S_CUB : S_RD;
        end
        // The cubic samples its operands once they have all settled.
        S_CUB:  state_q <= S_ROW;
        S_ROW: begin
          if (cub_done) begin
            if (cub_last_q) begin
              state_q <= S_FIN;
            end else if (ty_q == 2'd3) begin
              cub_last_q <= 1'b1;
              state_q    <= S_CUB;
            end else begin
              ty_q    <= ty_q + 2'd1;
              state_q <= S_RD;
            end
          end
        end
        S_FIN: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (state_q == S_POS) begin
      posx_q <= bir_pkg::PosBits'(ratiox) * bir_pkg::PosBits'(col_q);
      posy_q <= bir_pkg::PosBits'(ratioy) * bir_pkg::PosBits'(row_q);
    end
    if (state_q == S_TAPS) begin
      tapx_q <= bir_pkg::make_taps(posx_q, ratiox, col_q != '0, in_w_q);
      tapy_q <= bir_pkg::make_taps(posy_q, ratioy, row_q != '0, in_h_q);
    end
    if (state_q == S_CAP) begin
      pix_q[tx_q] <= bir_pkg::SampBits'({rdata, bir_pkg::FracBits'(0)});
    end
    if ((state_q == S_ROW) && cub_done && !cub_last_q) begin
      rows_q[ty_q] <= cub_res;
    end
    if (state_q == S_FIN) begin
      if (fin < 0) begin
        value_q <= 8'd0;
        clip_q  <= 1'b1;
      end else if (fin > bir_pkg::SampBits'(255)) begin
        value_q <= 8'd255;
        clip_q  <= 1'b1;
      end else begin
        value_q <= fin[7:0];
        clip_q  <= 1'b0;
      end
    end
  end

  // A compute request always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == bir_pkg::CmdCompute) |=> busy)
    else $error("compute request did not start the sequencer");

  // A write request leaves the block free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == bir_pkg::CmdWrite) |=> !busy)
    else $error("write request made the block busy");

  // A result comes only at the end of a compute.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of a compute");

  // A clipped result sits on a rail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |-> (value_o == 8'd0 || value_o == 8'd255))
    else $error("clipped result not saturated");

endmodule

`default_nettype wire
